// ===== rtl/per_pkg.sv =====
`timescale 1ns / 1ps

package per_pkg;

   // Default number of table slots.
   localparam int TABLE_ENTRIES_DEF = 16;

   // Operation codes carried in the op field of a request word.
   localparam logic [2:0] OP_REQ_REGISTER = 3'd0;
   localparam logic [2:0] OP_REQ_ACTION   = 3'd1;
   localparam logic [2:0] OP_RECORD       = 3'd2;
   localparam logic [2:0] OP_APPLY        = 3'd3;
   localparam logic [2:0] OP_PLAYBACK     = 3'd4;
   localparam logic [2:0] OP_CLEAR        = 3'd5;
   localparam logic [2:0] OP_WRITE_ENTRY  = 3'd6;

   // Codes reported in the fired field.
   localparam logic [1:0] FIRED_NONE = 2'd0;
   localparam logic [1:0] FIRED_ON   = 2'd1;
   localparam logic [1:0] FIRED_OFF  = 2'd2;

   // One request word.
   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] position;
      logic        request_flag;
      logic [3:0]  entry_index;
      logic        entry_level;
   } req_type;

   // One response word.
   typedef struct packed {
      logic [1:0] fired;
      logic       output_level;
      logic       pending_level;
      logic [4:0] recorded_count;
      logic [4:0] playback_position;
      logic       table_full;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

endpackage

// ===== rtl/per_datapath.sv =====
`timescale 1ns / 1ps

module per_datapath #(
   parameter int TABLE_ENTRIES = per_pkg::TABLE_ENTRIES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  per_pkg::cmd_type cmd,
   input  per_pkg::req_type req_data,
   output per_pkg::rsp_type rsp_data
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   typedef struct packed {
      logic [15:0] position;
      logic        level;
   } entry_type;

   // Table storage, valid bits make never-written or cleared slots read as zero.
   entry_type              table_mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] vld_ff;

   // Captured request and registered table read.
   per_pkg::req_type item_ff;
   entry_type        rd_entry_ff;
   logic             rd_vld_ff;

   // Architectural state.
   logic [CNT_W-1:0] rec_ff, rec_in;
   logic [CNT_W-1:0] play_ff, play_in;
   logic             cur_lvl_ff, cur_lvl_in;
   logic             nxt_lvl_ff, nxt_lvl_in;
   logic             reg_pend_ff, reg_pend_in;
   logic             act_pend_ff, act_pend_in;
   per_pkg::rsp_type rsp_ff, rsp_in;

   logic [CNT_W-1:0] prev_idx;
   logic [IDX_W-1:0] rd_addr;
   logic [15:0]      ent_pos;
   logic             ent_lvl;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_entry;
   logic             clr_all;
   logic [CNT_W-1:0] rec_idx;
   logic [1:0]       fired;
   logic             full;

   // Read address: the awaited entry for playback, the newest entry otherwise.
   always_comb begin
      prev_idx = (rec_ff != '0) ? (rec_ff - CNT_W'(1)) : '0;
      if (req_data.op == per_pkg::OP_PLAYBACK) begin
         rd_addr = play_ff[IDX_W-1:0];
      end else begin
         rd_addr = prev_idx[IDX_W-1:0];
      end
   end

   // Capture the request word and read the table in the same cycle.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff     <= req_data;
         rd_entry_ff <= table_mem[rd_addr];
         rd_vld_ff   <= vld_ff[rd_addr];
      end
   end

   assign ent_pos = rd_vld_ff ? rd_entry_ff.position : 16'd0;
   assign ent_lvl = rd_vld_ff ? rd_entry_ff.level : 1'b0;

   // Execute the captured operation.
   always_comb begin
      rec_in      = rec_ff;
      play_in     = play_ff;
      cur_lvl_in  = cur_lvl_ff;
      nxt_lvl_in  = nxt_lvl_ff;
      reg_pend_in = reg_pend_ff;
      act_pend_in = act_pend_ff;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_entry    = '0;
      clr_all     = 1'b0;
      rec_idx     = rec_ff;
      fired       = per_pkg::FIRED_NONE;
      full        = 1'b0;

      unique case (item_ff.op)
         per_pkg::OP_REQ_REGISTER: begin
            nxt_lvl_in  = ~cur_lvl_ff;
            reg_pend_in = item_ff.request_flag;
         end
         per_pkg::OP_REQ_ACTION: begin
            nxt_lvl_in  = ~cur_lvl_ff;
            act_pend_in = item_ff.request_flag;
         end
         per_pkg::OP_RECORD: begin
            if (reg_pend_ff) begin
               reg_pend_in = 1'b0;
               // Same position as the newest entry overwrites it.
               if ((rec_ff != '0) && (ent_pos == item_ff.position)) begin
                  rec_idx = rec_ff - CNT_W'(1);
               end
               if (rec_idx < CNT_W'(TABLE_ENTRIES)) begin
                  wr_en             = 1'b1;
                  wr_addr           = rec_idx[IDX_W-1:0];
                  wr_entry.position = item_ff.position;
                  wr_entry.level    = nxt_lvl_ff;
                  rec_in            = rec_idx + CNT_W'(1);
               end else begin
                  full = 1'b1;
               end
            end
         end
         per_pkg::OP_APPLY: begin
            if (act_pend_ff) begin
               act_pend_in = 1'b0;
               cur_lvl_in  = nxt_lvl_ff;
               fired       = nxt_lvl_ff ? per_pkg::FIRED_ON : per_pkg::FIRED_OFF;
            end
         end
         per_pkg::OP_PLAYBACK: begin
            // A match loads pending and applies it at once.
            if ((play_ff < CNT_W'(TABLE_ENTRIES)) && (ent_pos == item_ff.position)) begin
               nxt_lvl_in  = ent_lvl;
               play_in     = play_ff + CNT_W'(1);
               act_pend_in = 1'b0;
               cur_lvl_in  = ent_lvl;
               fired       = ent_lvl ? per_pkg::FIRED_ON : per_pkg::FIRED_OFF;
            end
         end
         per_pkg::OP_CLEAR: begin
            clr_all = 1'b1;
            rec_in  = '0;
            play_in = '0;
         end
         per_pkg::OP_WRITE_ENTRY: begin
            if (32'(item_ff.entry_index) < 32'(TABLE_ENTRIES)) begin
               wr_en             = 1'b1;
               wr_addr           = IDX_W'(item_ff.entry_index);
               wr_entry.position = item_ff.position;
               wr_entry.level    = item_ff.entry_level;
            end
         end
         default: begin
         end
      endcase

      rsp_in.fired             = fired;
      rsp_in.output_level      = cur_lvl_in;
      rsp_in.pending_level     = nxt_lvl_in;
      rsp_in.recorded_count    = 5'(rec_in);
      rsp_in.playback_position = 5'(play_in);
      rsp_in.table_full        = full;
   end

   // Table write port.
   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en) begin
         table_mem[wr_addr] <= wr_entry;
      end
   end

   // Control state and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         rec_ff      <= '0;
         play_ff     <= '0;
         cur_lvl_ff  <= 1'b0;
         nxt_lvl_ff  <= 1'b0;
         reg_pend_ff <= 1'b0;
         act_pend_ff <= 1'b0;
      end else if (cmd.commit) begin
         if (clr_all) begin
            vld_ff <= '0;
         end else if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         rec_ff      <= rec_in;
         play_ff     <= play_in;
         cur_lvl_ff  <= cur_lvl_in;
         nxt_lvl_ff  <= nxt_lvl_in;
         reg_pend_ff <= reg_pend_in;
         act_pend_ff <= act_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== rtl/per_control.sv =====
`timescale 1ns / 1ps

module per_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output per_pkg::cmd_type cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   // One word in flight; the response register may still hold the previous one.
   assign req_ready   = (state_ff == ST_IDLE);
   assign cmd.capture = req_valid && req_ready;
   assign cmd.commit  = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid   = rsp_valid_ff;

   // State and response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
               end
               if (cmd.capture) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (cmd.commit) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end else if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== rtl/position_event_recorder.sv =====
`timescale 1ns / 1ps

// Position event recorder: records on/off switch events against machine
// position numbers in a table and plays them back.
// Request channel (req_valid, req_ready, req_data) takes one word per
// operation: register or action request, record tick, apply, playback tick,
// clear, or a direct table entry write. Every request word yields exactly one
// response word on the rsp_ channel with the fired code, both levels, the
// record and playback indices and the table-full flag.
// Each accepted word is captured together with a registered read of the table,
// then committed to the indices, levels and response register once that
// register is free; no new word is accepted until the current one is committed.
// The response sits in an output register, so a new request is accepted
// while the previous response waits; that request then holds in execution
// until the receiver takes the waiting response.
// Reset (synchronous) empties the table, zeroes both indices, levels and
// request flags, and drops any response not yet taken.
module position_event_recorder #(
   parameter int TABLE_ENTRIES = per_pkg::TABLE_ENTRIES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  per_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output per_pkg::rsp_type rsp_data
);

   per_pkg::cmd_type cmd;

   // Sequencing of capture and commit.
   per_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Table, indices, levels and response register.
   per_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

// ===== rtl/per_checker.sv =====
`timescale 1ns / 1ps

module per_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input per_pkg::rsp_type rsp_data
);

   // A stalled response word holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   // Only one request word is taken per execution.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while one is in execution");

   // Reset drops any pending response.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A fired code agrees with the output level and is never the unused code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.fired == per_pkg::FIRED_NONE)
         || (rsp_data.fired == per_pkg::FIRED_ON && rsp_data.output_level)
         || (rsp_data.fired == per_pkg::FIRED_OFF && !rsp_data.output_level))
      else $error("fired code inconsistent with output level");

endmodule

bind position_event_recorder per_checker u_per_checker (.*);
